// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL; ltc_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/ltc_pkg.sv -----
`default_nettype none

package ltc_pkg;

    localparam int TOKEN_COUNT_W = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef logic [1:0] t_inc;
    typedef logic [1:0] t_line_pos;

    localparam t_line_pos LINE_POS_MAX = 2'd2;

    typedef struct packed {
        logic valid;
        t_inc inc;
    } t_queue_wr;

    typedef struct packed {
        logic empty;
        t_inc inc;
    } t_queue_rd;

    function automatic logic is_op(input logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GREATER, CH_LESS, CH_EQUAL};
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_op(c) || (c inside {CH_SPACE, CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN,
                                      CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_DIGIT_0:CH_DIGIT_9]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ltc_front.sv -----
`default_nettype none

module ltc_front
    import ltc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_command,
    input  wire logic [7:0] i_character,
    output t_queue_wr       o_wr
);

    logic      r_in_string, n_in_string;
    logic      r_token_open, n_token_open;
    logic      r_pending_op, n_pending_op;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_before_prev, n_before_prev;
    t_line_pos r_line_pos, n_line_pos;
    t_inc      w_inc;
    logic      w_skip;
    logic      w_exponent;

    // A sign after a digit and an E stays inside the number.
    assign w_exponent = ((i_character == CH_PLUS) || (i_character == CH_MINUS)) &&
                        (r_line_pos == LINE_POS_MAX) && (r_prev == CH_UPPER_E) &&
                        is_digit(r_before_prev);

    always_comb begin
        n_in_string   = r_in_string;
        n_token_open  = r_token_open;
        n_pending_op  = r_pending_op;
        n_prev        = r_prev;
        n_before_prev = r_before_prev;
        n_line_pos    = r_line_pos;
        w_inc         = 2'd0;
        w_skip        = 1'b0;
        if (i_command == CMD_EOL) begin
            w_inc         = {1'b0, r_token_open};
            n_token_open  = 1'b0;
            n_pending_op  = 1'b0;
            n_prev        = 8'd0;
            n_before_prev = 8'd0;
            n_line_pos    = 2'd0;
        end else begin
            if (r_pending_op) begin
                n_pending_op = 1'b0;
                w_skip       = is_op(i_character);
            end
            if (!w_skip) begin
                if (is_delim(i_character) && !r_in_string) begin
                    if (w_exponent) begin
                        n_token_open = 1'b1;
                    end else begin
                        w_inc = t_inc'({1'b0, r_token_open}) +
                                t_inc'({1'b0, i_character != CH_SPACE});
                        n_token_open = 1'b0;
                        if (is_op(i_character)) begin
                            n_pending_op = 1'b1;
                        end
                    end
                end else if (i_character == CH_QUOTE && !r_in_string) begin
                    n_in_string  = 1'b1;
                    n_token_open = 1'b1;
                end else if (i_character == CH_QUOTE) begin
                    n_in_string  = 1'b0;
                    w_inc        = 2'd1;
                    n_token_open = 1'b0;
                end else begin
                    n_token_open = 1'b1;
                end
            end
            n_before_prev = r_prev;
            n_prev        = i_character;
            if (r_line_pos != LINE_POS_MAX) begin
                n_line_pos = r_line_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string   <= 1'b0;
            r_token_open  <= 1'b0;
            r_pending_op  <= 1'b0;
            r_prev        <= 8'd0;
            r_before_prev <= 8'd0;
            r_line_pos    <= 2'd0;
        end else if (i_accept) begin
            r_in_string   <= n_in_string;
            r_token_open  <= n_token_open;
            r_pending_op  <= n_pending_op;
            r_prev        <= n_prev;
            r_before_prev <= n_before_prev;
            r_line_pos    <= n_line_pos;
        end
    end

    assign o_wr.valid = i_accept;
    assign o_wr.inc   = w_inc;

endmodule

`default_nettype wire

// ----- hdl/ltc_queue.sv -----
`default_nettype none

module ltc_queue
    import ltc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_queue_wr i_wr,
    input  wire logic      i_rd,
    output logic           o_full,
    output t_queue_rd      o_rd
);

    t_inc                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_fill;
    logic                   w_do_wr;
    logic                   w_do_rd;

    assign o_full   = (r_fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_rd.empty = (r_fill == '0);
    assign o_rd.inc = r_mem[r_rd_ptr];
    assign w_do_wr  = i_wr.valid && !o_full;
    assign w_do_rd  = i_rd && !o_rd.empty;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_wr && !w_do_rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_do_rd && !w_do_wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ltc_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module ltc_back
    import ltc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_queue_rd             i_rd,
    output logic                       o_take,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [COUNT_WIDTH-1:0]     o_count
);

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_out_valid;
    logic [COUNT_WIDTH:0]   w_sum;
    logic                   w_out_pop;

    assign w_out_pop = i_pop && r_out_valid;
    assign o_take    = !i_rd.empty && (!r_out_valid || w_out_pop);
    assign w_sum     = {1'b0, r_count} + (COUNT_WIDTH+1)'(i_rd.inc);

    // The count saturates at its maximum.
    assign n_count = w_sum[COUNT_WIDTH] ? '1 : w_sum[COUNT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (w_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_count = r_count;

    `ASSERT_NEXT(a_take_shows_word, i_clk, i_rst_n, o_take, !o_empty)
    `ASSERT_NEXT(a_count_holds, i_clk, i_rst_n, !o_take, $stable(r_count))
    `ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, o_take, r_count >= $past(r_count))

endmodule

`default_nettype wire

// ----- hdl/lexer_token_counter.sv -----
// Each accepted word is classified, queued and added into the registered count when
// the result side is free. Throughput: one word per cycle while full is low; a
// four-entry queue between classifier and counter absorbs result stalls, and full rises
// once it fills. Reset: synchronous active-low i_rst_n clears the lexer state, the queue
// and the count, and empties the result side.
`default_nettype none

module lexer_token_counter
    import ltc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_character,
    output logic             empty,
    input  wire logic        pop,
    output logic [TOKEN_COUNT_W-1:0] o_token_count
);

    t_queue_wr              w_wr;
    t_queue_rd              w_rd;
    logic                   w_take;
    logic [COUNT_WIDTH-1:0] w_count;

    ltc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !full),
        .i_command   (i_command),
        .i_character (i_character),
        .o_wr        (w_wr)
    );

    ltc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_rd    (w_take),
        .o_full  (full),
        .o_rd    (w_rd)
    );

    ltc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_rd),
        .o_take  (w_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_count (w_count)
    );

    generate
        if (COUNT_WIDTH >= TOKEN_COUNT_W) begin : g_trunc
            assign o_token_count = w_count[TOKEN_COUNT_W-1:0];
        end else begin : g_ext
            assign o_token_count = {{(TOKEN_COUNT_W-COUNT_WIDTH){1'b0}}, w_count};
        end
    endgenerate

endmodule

`default_nettype wire

// ----- tb/lexer_token_counter_test.sv -----
`default_nettype none

module lexer_token_counter_test;
    import ltc_pkg::*;

    // A narrow count lets the run reach the saturation limit.
    localparam int          COUNT_WIDTH = 9;
    localparam logic [63:0] COUNT_MAX   = {64{1'b1}} >> (64 - COUNT_WIDTH);
    localparam int          STALL_LIMIT = 1000;
    localparam int          RANDOM_WORDS = 1700;

    localparam logic [7:0] OPERATORS [7] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                             CH_GREATER, CH_LESS, CH_EQUAL};
    localparam logic [7:0] PUNCTUATION [8] = '{CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN,
                                               CH_LBRACKET, CH_RBRACKET, CH_LBRACE,
                                               CH_RBRACE};
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    typedef struct packed {
        logic       command;
        logic [7:0] character;
    } t_text_word;

    class token_count_tracker;
        logic [63:0] count;
        logic [63:0] count_max;
        logic        in_string;
        logic        token_open;
        logic        pending_op;
        logic [7:0]  prev_char;
        logic [7:0]  prev2_char;
        t_line_pos   line_pos;
        logic [TOKEN_COUNT_W-1:0] expected_counts[$];
        int          errors;
        int          checked;

        function new(logic [63:0] limit);
            count_max  = limit;
            count      = '0;
            in_string  = 1'b0;
            token_open = 1'b0;
            pending_op = 1'b0;
            prev_char  = '0;
            prev2_char = '0;
            line_pos   = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function logic is_operator(logic [7:0] ch);
            return ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                              CH_GREATER, CH_LESS, CH_EQUAL};
        endfunction

        function void bump();
            if (count < count_max) begin
                count = count + 1;
            end
        endfunction

        function void note_word(logic command, logic [7:0] ch);
            logic op;
            logic delim;
            logic joined;
            if (command == CMD_EOL) begin
                if (token_open) begin
                    bump();
                end
                token_open = 1'b0;
                pending_op = 1'b0;
                prev_char  = '0;
                prev2_char = '0;
                line_pos   = '0;
            end else begin
                op     = is_operator(ch);
                delim  = op || (ch inside {CH_SPACE, CH_COMMA, CH_SEMI, CH_LPAREN,
                                           CH_RPAREN, CH_LBRACKET, CH_RBRACKET,
                                           CH_LBRACE, CH_RBRACE});
                joined = 1'b0;
                if (pending_op) begin
                    pending_op = 1'b0;
                    joined     = op;
                end
                if (!joined) begin
                    if (delim && !in_string) begin
                        if ((ch == CH_PLUS || ch == CH_MINUS) && line_pos >= LINE_POS_MAX &&
                            prev_char == CH_UPPER_E &&
                            prev2_char >= CH_DIGIT_0 && prev2_char <= CH_DIGIT_9) begin
                            token_open = 1'b1;
                        end else begin
                            if (token_open) begin
                                bump();
                            end
                            token_open = 1'b0;
                            if (ch != CH_SPACE) begin
                                bump();
                                pending_op = op;
                            end
                        end
                    end else if (ch == CH_QUOTE && !in_string) begin
                        in_string  = 1'b1;
                        token_open = 1'b1;
                    end else if (ch == CH_QUOTE) begin
                        in_string  = 1'b0;
                        bump();
                        token_open = 1'b0;
                    end else begin
                        token_open = 1'b1;
                    end
                end
                prev2_char = prev_char;
                prev_char  = ch;
                if (line_pos < LINE_POS_MAX) begin
                    line_pos = line_pos + 1'b1;
                end
            end
            expected_counts.insert(expected_counts.size(), count[TOKEN_COUNT_W-1:0]);
        endfunction

        function void check_count(logic [TOKEN_COUNT_W-1:0] actual);
            logic [TOKEN_COUNT_W-1:0] wanted;
            if (expected_counts.size() == 0) begin
                $error("token_count: result %0d arrived with no expected count", actual);
                errors++;
            end else begin
                wanted = expected_counts.pop_front();
                checked++;
                if (actual !== wanted) begin
                    $error("token_count: expected %0d, actual %0d", wanted, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic                     i_command;
    logic [7:0]               i_character;
    logic                     empty;
    logic                     pop;
    logic [TOKEN_COUNT_W-1:0] o_token_count;

    token_count_tracker tracker;
    t_text_word         text_stream[$];
    string              word_chars = "abcdefxyzABCDEFXYZ0123456789_";
    int                 eol_words;
    int                 send_calm;
    int                 recv_calm;
    int                 stall_cycles;

    lexer_token_counter #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_command(i_command),
        .i_character(i_character),
        .empty(empty),
        .pop(pop),
        .o_token_count(o_token_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void add_word(logic command, logic [7:0] ch);
        text_stream.insert(text_stream.size(), t_text_word'({command, ch}));
        if (command == CMD_EOL) begin
            eol_words++;
        end
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_DIGIT_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_word_char();
        return word_chars[$urandom_range(0, word_chars.len() - 1)];
    endfunction

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(20, 60);
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic build_stimulus();
        int target;
        int pick;
        int len;
        add_word(CMD_TEXT, CH_DIGIT_0 + 8'd1);
        add_word(CMD_TEXT, CH_UPPER_E);
        add_word(CMD_TEXT, CH_PLUS);
        add_word(CMD_TEXT, CH_DIGIT_9);
        add_word(CMD_TEXT, CH_LESS);
        add_word(CMD_TEXT, CH_EQUAL);
        add_word(CMD_TEXT, word_chars[0]);
        add_word(CMD_TEXT, CH_COMMA);
        add_word(CMD_TEXT, CH_QUOTE);
        add_word(CMD_TEXT, 8'hFF);
        add_word(CMD_EOL, 8'hFF);
        add_word(CMD_TEXT, CH_SEMI);
        add_word(CMD_TEXT, CH_QUOTE);
        add_word(CMD_TEXT, CH_LBRACKET);
        add_word(CMD_TEXT, CH_RBRACKET);
        add_word(CMD_TEXT, CH_LBRACE);
        add_word(CMD_TEXT, CH_RBRACE);
        add_word(CMD_TEXT, CH_LPAREN);
        add_word(CMD_TEXT, CH_RPAREN);
        add_word(CMD_TEXT, CH_STAR);
        add_word(CMD_TEXT, CH_SLASH);
        add_word(CMD_TEXT, CH_GREATER);
        add_word(CMD_TEXT, CH_MINUS);
        add_word(CMD_TEXT, CH_SPACE);
        add_word(CMD_TEXT, 8'h00);
        add_word(CMD_EOL, 8'h00);

        target = text_stream.size() + RANDOM_WORDS;
        while (text_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                len = $urandom_range(1, 6);
                repeat (len) add_word(CMD_TEXT, random_word_char());
            end else if (pick < 35) begin
                len = $urandom_range(1, 3);
                repeat (len) add_word(CMD_TEXT, random_digit());
                if ($urandom_range(0, 3) == 0) begin
                    add_word(CMD_TEXT, random_word_char());
                end
                add_word(CMD_TEXT, CH_UPPER_E);
                add_word(CMD_TEXT, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                len = $urandom_range(1, 2);
                repeat (len) add_word(CMD_TEXT, random_digit());
            end else if (pick < 50) begin
                len = $urandom_range(1, 3);
                repeat (len) add_word(CMD_TEXT, OPERATORS[$urandom_range(0, 6)]);
            end else if (pick < 60) begin
                add_word(CMD_TEXT, PUNCTUATION[$urandom_range(0, 7)]);
            end else if (pick < 72) begin
                len = $urandom_range(1, 2);
                repeat (len) add_word(CMD_TEXT, CH_SPACE);
            end else if (pick < 82) begin
                add_word(CMD_TEXT, CH_QUOTE);
                len = $urandom_range(0, 5);
                repeat (len) add_word(CMD_TEXT, 8'($urandom_range(PRINT_LO, PRINT_HI)));
                if ($urandom_range(0, 3) == 0) begin
                    add_word(CMD_EOL, 8'($urandom_range(0, 255)));
                    add_word(CMD_TEXT, random_word_char());
                end
                if ($urandom_range(0, 4) != 0) begin
                    add_word(CMD_TEXT, CH_QUOTE);
                end
            end else if (pick < 90) begin
                add_word(CMD_EOL, 8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) add_word(CMD_TEXT, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_words();
        int gap;
        foreach (text_stream[i]) begin
            gap = draw_gap(send_calm);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push        <= 1'b1;
            i_command   <= text_stream[i].command;
            i_character <= text_stream[i].character;
            do @(posedge i_clk); while (full);
            tracker.note_word(text_stream[i].command, text_stream[i].character);
        end
        push <= 1'b0;
    endtask

    task automatic take_counts();
        int gap;
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            tracker.check_count(o_token_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL lexer_token_counter");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_command    = CMD_TEXT;
        i_character  = '0;
        eol_words    = 0;
        send_calm    = 0;
        recv_calm    = 0;
        stall_cycles = 0;
        tracker      = new(COUNT_MAX);
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_counts();
        join_none
        send_words();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d words, %0d of them end-of-line, and checked %0d counts.",
                 text_stream.size(), eol_words, tracker.checked);
        $display("The count ended at %0d with a saturation limit of %0d.",
                 tracker.count, COUNT_MAX);
        if (tracker.errors == 0) begin
            $display("PASS lexer_token_counter");
        end else begin
            $display("FAIL lexer_token_counter");
        end
        $finish;
    end

endmodule

`default_nettype wire
